// ===== rtl/bdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin decimator package
// Shared widths, mode codes, the closed-bin record type and the result type.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int BIN_BITS      = 12;
  localparam int MAX_BIN_LEN   = 16384;
  // The count saturates one above the maximum length, which marks overflow.
  localparam int COUNT_BITS    = $clog2(MAX_BIN_LEN + 2);
  localparam int SUM_BITS      = SAMPLE_BITS + $clog2(MAX_BIN_LEN);
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int TDATA_BITS    = ((SAMPLE_BITS + BIN_BITS + 7) / 8) * 8;

  localparam logic [1:0] MODE_MAX    = 2'd0;
  localparam logic [1:0] MODE_MINMAX = 2'd1;
  localparam logic [1:0] MODE_AVG    = 2'd2;
  localparam logic [1:0] MODE_FIRST  = 2'd3;

  // Everything the back end needs to turn one closed bin into results.
  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [SAMPLE_BITS-1:0] max_val;
    logic signed [SAMPLE_BITS-1:0] min_val;
    logic                         min_first;
    logic signed [SAMPLE_BITS-1:0] first_val;
    logic signed [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0]        count;
    logic [BIN_BITS-1:0]          bin;
    logic                         last_of_run;
    logic                         frame_end;
  } bdm_rec_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [BIN_BITS-1:0]          bin;
    logic                         last_of_run;
    logic                         frame_end;
    logic                         overflow;
  } bdm_res_t;

endpackage

// ===== rtl/bin_decimator_multimode_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimode bin decimator
// Reduces runs of equal-bin spectrum samples to max, min/max, average or
// first value per bin.
// ----------------------------------------------------------------------------
// The block takes one sample word per cycle as long as its four-entry record
// queue has room and no second record is pending. A bin closes when the bin
// index changes or when the word with tlast arrives; the front end then
// queues one record, or two when both happen on the same word, in which case
// s_tready drops while the second record waits in the pending register for
// room in the queue. The back end takes a record only in its idle state and
// then loads one result word per output state, so max, first and average
// modes give one word per bin and min-max mode two. Average mode adds a
// bit-serial divider between taking the record and the output state; this
// divider sets the sustained rate whenever bins are short in average mode.
// The mode register is sampled when a bin closes and must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module bin_decimator_multimode_core import bdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: decimation_mode (0 max, 1 min/max, 2 average, 3 first).
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  // Sample words in.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,   // [23:0] sample, [35:24] bin, rest zero
  input  logic                  s_tlast,   // last_sample
  // Result words out.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,   // [23:0] value, [35:24] out_bin, rest zero
  output logic                  m_tlast,   // frame_end
  output logic [1:0]            m_tuser    // [0] last_of_run, [1] overflow
);

  logic [1:0] decimation_mode;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_empty;
  bdm_rec_t   push_rec;
  bdm_rec_t   pop_rec;
  bdm_res_t   out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_mode <= MODE_MAX;
    end else if (cfg_we) begin
      decimation_mode <= cfg_wdata;
    end
  end

  // Front end: tracks the open bin and produces a record per closed bin.
  bdm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (decimation_mode),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample      (s_tdata[SAMPLE_BITS-1:0]),
    .bin_idx     (s_tdata[SAMPLE_BITS+BIN_BITS-1:SAMPLE_BITS]),
    .last_sample (s_tlast),
    .push        (push),
    .push_rec    (push_rec),
    .full        (fifo_full)
  );

  // The queue lets the input keep streaming while the back end divides.
  bdm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (fifo_full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (fifo_empty)
  );

  // Back end: emits one or two result words per record.
  bdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (fifo_empty),
    .rec       (pop_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {{(TDATA_BITS-SAMPLE_BITS-BIN_BITS){1'b0}}, out_res.bin, out_res.value};
  assign m_tlast = out_res.frame_end;
  assign m_tuser = {out_res.overflow, out_res.last_of_run};

  // A frame end is always the final word of the input word that caused it.
  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("frame_end without last_of_run");

  // The front end never writes into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("record pushed into a full queue");

  // The back end never takes a record from an empty queue.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_empty)
    else $error("record popped from an empty queue");

  // Input is held off whenever the queue has no room.
  a_stall_on_full: assert property (@(posedge clk) disable iff (rst)
    fifo_full |-> !s_tready)
    else $error("input accepted while queue full");

endmodule

// ===== rtl/bdm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closed-bin record queue
// Small register queue between the front and the back end.
// ----------------------------------------------------------------------------
module bdm_fifo import bdm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bdm_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output bdm_rec_t pop_rec,
  output logic     empty
);

  bdm_rec_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   fill;

  assign full    = (fill == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bdm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin average divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module bdm_div import bdm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0]        divisor,
  output logic                         done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   dvs;
  logic [SUM_BITS-1:0]     quo;
  logic                    neg;
  logic [COUNT_BITS:0]     trial;
  logic                    fits;
  logic [SUM_BITS-1:0]     signed_quo;

  assign trial      = {rem, quo[SUM_BITS-1]};
  assign fits       = (trial >= {1'b0, dvs});
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed_quo[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_BITS-1];
      quo <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // The remainder stays below the divisor, so it fits back into COUNT_BITS.
      rem <= fits ? COUNT_BITS'(trial - {1'b0, dvs}) : trial[COUNT_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bdm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin decimator front end
// Accumulates the open bin and queues a record each time a bin closes.
// ----------------------------------------------------------------------------
module bdm_front import bdm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   mode,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [BIN_BITS-1:0]          bin_idx,
  input  logic                         last_sample,
  output logic                         push,
  output bdm_rec_t                     push_rec,
  input  logic                         full
);

  logic [BIN_BITS-1:0]           open_bin;
  logic                          bin_open;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic                          min_first;
  logic signed [SAMPLE_BITS-1:0] first_value;
  logic signed [SUM_BITS-1:0]    run_sum;
  logic [COUNT_BITS-1:0]         run_count;

  logic                          pend_valid;
  bdm_rec_t                      pend_rec;

  logic signed [SAMPLE_BITS-1:0] run_max_next;
  logic signed [SAMPLE_BITS-1:0] run_min_next;
  logic                          min_first_next;
  logic signed [SAMPLE_BITS-1:0] first_value_next;
  logic signed [SUM_BITS-1:0]    run_sum_next;
  logic [COUNT_BITS-1:0]         run_count_next;

  logic                          accept;
  logic                          match;
  logic                          close_old;
  logic signed [SUM_BITS-1:0]    sample_ext;
  bdm_rec_t                      rec_old;
  bdm_rec_t                      rec_new;

  assign in_ready   = !pend_valid && !full;
  assign accept     = in_valid && in_ready;
  assign match      = bin_open && (bin_idx == open_bin);
  assign close_old  = bin_open && !match;
  assign sample_ext = {{(SUM_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};

  always_comb begin
    run_max_next     = run_max;
    run_min_next     = run_min;
    min_first_next   = min_first;
    first_value_next = first_value;
    run_sum_next     = run_sum;
    run_count_next   = run_count;
    if (match) begin
      if (sample > run_max) begin
        run_max_next   = sample;
        min_first_next = 1'b1;
      end
      if (sample < run_min) begin
        run_min_next   = sample;
        min_first_next = 1'b0;
      end
      if (run_count < COUNT_BITS'(MAX_BIN_LEN)) begin
        run_sum_next   = run_sum + sample_ext;
        run_count_next = run_count + 1'b1;
      end else begin
        run_count_next = COUNT_BITS'(MAX_BIN_LEN + 1);
      end
    end else begin
      run_max_next     = sample;
      run_min_next     = sample;
      min_first_next   = 1'b0;
      first_value_next = sample;
      run_sum_next     = sample_ext;
      run_count_next   = COUNT_BITS'(1);
    end
  end

  always_comb begin
    rec_old.mode        = mode;
    rec_old.max_val     = run_max;
    rec_old.min_val     = run_min;
    rec_old.min_first   = min_first;
    rec_old.first_val   = first_value;
    rec_old.sum         = run_sum;
    rec_old.count       = run_count;
    rec_old.bin         = open_bin;
    rec_old.last_of_run = !last_sample;
    rec_old.frame_end   = 1'b0;

    rec_new.mode        = mode;
    rec_new.max_val     = run_max_next;
    rec_new.min_val     = run_min_next;
    rec_new.min_first   = min_first_next;
    rec_new.first_val   = first_value_next;
    rec_new.sum         = run_sum_next;
    rec_new.count       = run_count_next;
    rec_new.bin         = match ? open_bin : bin_idx;
    rec_new.last_of_run = 1'b1;
    rec_new.frame_end   = 1'b1;
  end

  // A bin change together with the frame end closes two bins; the second
  // record waits in the pending register until the queue has room.
  always_comb begin
    push     = 1'b0;
    push_rec = rec_old;
    if (pend_valid) begin
      push     = !full;
      push_rec = pend_rec;
    end else if (accept) begin
      if (close_old) begin
        push = 1'b1;
      end else if (last_sample) begin
        push     = 1'b1;
        push_rec = rec_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      open_bin    <= rec_new.bin;
      run_max     <= run_max_next;
      run_min     <= run_min_next;
      min_first   <= min_first_next;
      first_value <= first_value_next;
      run_sum     <= run_sum_next;
      run_count   <= run_count_next;
    end
    if (accept && close_old && last_sample) begin
      pend_rec <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_open   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        bin_open <= !last_sample;
      end
      if (pend_valid) begin
        pend_valid <= full;
      end else if (accept && close_old && last_sample) begin
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bdm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin decimator back end
// Turns queued bin records into result words through a registered output.
// ----------------------------------------------------------------------------
module bdm_back import bdm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     empty,
  input  bdm_rec_t rec,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output bdm_res_t out_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT0 = 2'd2;
  localparam logic [1:0] ST_OUT1 = 2'd3;

  logic [1:0]                    st;
  logic [1:0]                    st_next;
  bdm_rec_t                      cur;
  logic                          out_free;
  logic                          load;
  bdm_res_t                      res_next;
  logic                          rec_ovf;
  logic                          cur_ovf;
  logic [COUNT_BITS-1:0]         divisor;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] quotient;
  logic signed [SAMPLE_BITS-1:0] first_res;

  assign out_free  = !out_valid || out_ready;
  assign rec_ovf   = rec.count > COUNT_BITS'(MAX_BIN_LEN);
  assign cur_ovf   = cur.count > COUNT_BITS'(MAX_BIN_LEN);
  assign divisor   = rec_ovf ? COUNT_BITS'(MAX_BIN_LEN) : rec.count;
  assign pop       = (st == ST_IDLE) && !empty;
  assign div_start = pop && (rec.mode == MODE_AVG);

  bdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rec.sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    unique case (cur.mode)
      MODE_MAX:    first_res = cur.max_val;
      MODE_MINMAX: first_res = cur.min_first ? cur.min_val : cur.max_val;
      MODE_AVG:    first_res = quotient;
      default:     first_res = cur.first_val;
    endcase
  end

  always_comb begin
    st_next              = st;
    load                 = 1'b0;
    res_next.value       = first_res;
    res_next.bin         = cur.bin;
    res_next.overflow    = cur_ovf;
    res_next.last_of_run = cur.last_of_run && (cur.mode != MODE_MINMAX);
    res_next.frame_end   = cur.frame_end && (cur.mode != MODE_MINMAX);
    unique case (st)
      ST_IDLE: begin
        if (!empty) begin
          st_next = (rec.mode == MODE_AVG) ? ST_DIV : ST_OUT0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_next = ST_OUT0;
        end
      end
      ST_OUT0: begin
        if (out_free) begin
          load    = 1'b1;
          st_next = (cur.mode == MODE_MINMAX) ? ST_OUT1 : ST_IDLE;
        end
      end
      default: begin
        res_next.value       = cur.min_first ? cur.max_val : cur.min_val;
        res_next.last_of_run = cur.last_of_run;
        res_next.frame_end   = cur.frame_end;
        if (out_free) begin
          load    = 1'b1;
          st_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rec;
    end
    if (load) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

endmodule

// ===== dv/bin_decimator_multimode_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimode bin decimator testbench
// Streams directed and random sample words through the core in all four
// decimation modes, and checks every result word field by field against a
// bin tracker kept inside the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module bin_decimator_multimode_core_test;
  import bdm_pkg::*;

  // Cycles to let pass after the last expected word before a mode write or
  // the end of the run. This covers the average-mode divider with margin.
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASE_WORDS = 21;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata;   // [23:0] sample, [35:24] bin, rest zero
  logic                  s_tlast;   // last_sample
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_BITS-1:0] m_tdata;   // [23:0] value, [35:24] out_bin, rest zero
  logic                  m_tlast;   // frame_end
  logic [1:0]            m_tuser;   // [0] last_of_run, [1] overflow

  bin_decimator_multimode_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  int errors          = 0;
  int words_sent      = 0;
  int results_checked = 0;

  // --------------------------------------------------------------------------
  // Bin tracker. It mirrors the open bin of the core: its index, the running
  // extremes and which of them came first, the first sample, the clipped sum
  // and the saturating count. The mode is looked at only when a bin closes.
  // --------------------------------------------------------------------------
  logic [1:0]          dec_mode    = MODE_MAX;
  logic [BIN_BITS-1:0] cur_bin     = '0;
  bit                  bin_is_open = 1'b0;
  longint              peak_max    = 0;
  longint              peak_min    = 0;
  longint              first_val   = 0;
  longint              bin_sum     = 0;
  bit                  min_leads   = 1'b0;
  int                  bin_len     = 0;

  // Words produced by the sample word being decimated, and all words that
  // the core still owes, oldest first.
  bdm_res_t closing[$];
  bdm_res_t pending_results[$];

  function automatic void put_result(longint v, bit ovf);
    bdm_res_t r;
    r.value       = v[SAMPLE_BITS-1:0];
    r.bin         = cur_bin;
    r.last_of_run = 1'b0;
    r.frame_end   = 1'b0;
    r.overflow    = ovf;
    closing.insert(closing.size(), r);
  endfunction

  // Closes the open bin and queues its result words under the current mode.
  function automatic void emit_bin();
    bit     ovf;
    longint n;
    ovf = bin_len > MAX_BIN_LEN;
    n   = ovf ? longint'(MAX_BIN_LEN) : longint'(bin_len);
    case (dec_mode)
      MODE_MAX: put_result(peak_max, ovf);
      MODE_MINMAX: begin
        if (min_leads) begin
          put_result(peak_min, ovf);
          put_result(peak_max, ovf);
        end else begin
          put_result(peak_max, ovf);
          put_result(peak_min, ovf);
        end
      end
      // Signed division truncates toward zero, as the core must.
      MODE_AVG: put_result((n != 0) ? bin_sum / n : 0, ovf);
      default: put_result(first_val, ovf);
    endcase
    bin_is_open = 1'b0;
  endfunction

  // Runs one accepted sample word through the tracker and appends the
  // words it causes to the expectation queue.
  function automatic void decimate_word(input logic signed [SAMPLE_BITS-1:0] smp,
                                        input logic [BIN_BITS-1:0] b, input bit last);
    longint sv;
    sv = smp;
    closing.delete();
    if (bin_is_open && b == cur_bin) begin
      // Strict compares: a repeat of an extreme does not move its position.
      if (sv > peak_max) begin
        peak_max  = sv;
        min_leads = 1'b1;
      end
      if (sv < peak_min) begin
        peak_min  = sv;
        min_leads = 1'b0;
      end
      if (bin_len < MAX_BIN_LEN) begin
        bin_sum += sv;
        bin_len++;
      end else begin
        bin_len = MAX_BIN_LEN + 1;
      end
    end else begin
      // A new index, or the first word after a frame end, opens a new bin.
      if (bin_is_open) emit_bin();
      cur_bin     = b;
      bin_is_open = 1'b1;
      peak_max    = sv;
      peak_min    = sv;
      first_val   = sv;
      bin_sum     = sv;
      min_leads   = 1'b0;
      bin_len     = 1;
    end
    if (last) begin
      emit_bin();
      closing[closing.size()-1].frame_end = 1'b1;
    end
    if (closing.size() != 0) closing[closing.size()-1].last_of_run = 1'b1;
    foreach (closing[i]) pending_results.insert(pending_results.size(), closing[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, timeout and the result side.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The slowest correct run needs well under a tenth of this time.
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // The sink draws a stall before every result word and then holds tready
  // high until a word is taken.
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
    end
  end

  function automatic void compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Every taken result word is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    bdm_res_t want;
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: value %0d, out_bin %0d",
               $signed(m_tdata[SAMPLE_BITS-1:0]), m_tdata[SAMPLE_BITS +: BIN_BITS]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("value", want.value, $signed(m_tdata[SAMPLE_BITS-1:0]));
        compare_field("out_bin", want.bin, m_tdata[SAMPLE_BITS +: BIN_BITS]);
        compare_field("last_of_run", want.last_of_run, m_tuser[0]);
        compare_field("frame_end", want.frame_end, m_tlast);
        compare_field("overflow", want.overflow, m_tuser[1]);
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks.
  // --------------------------------------------------------------------------

  // Offers one sample word after a random gap and returns at the edge
  // where the core takes it.
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [BIN_BITS-1:0] b, input bit last);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_BITS-SAMPLE_BITS-BIN_BITS){1'b0}}, b, smp};
    s_tlast  <= last;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    decimate_word(smp, b, last);
    words_sent++;
  endtask

  // Waits until every owed word has arrived, then lets the back end finish
  // any record still in flight.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the core idle.
  task automatic set_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dec_mode = m;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The mode comes out of reset as max. Full-scale samples, and a new
  // index arriving together with last, which closes two bins at once.
  task automatic test_reset_mode_max();
    send_word(S_MIN, 12'd0, 1'b0);
    send_word(S_MAX, 12'd0, 1'b0);
    send_word('0, 12'd0, 1'b0);
    send_word(SAMPLE_BITS'(5), 12'd4095, 1'b1);
    settle();
  endtask

  // A flat bin yields the same word twice. In the second bin the minimum
  // comes before the maximum, and a repeated minimum must not move it. The
  // last word changes the index and ends the frame, for four result words.
  task automatic test_min_max_order();
    set_mode(MODE_MINMAX);
    send_word(SAMPLE_BITS'(100), 12'd7, 1'b0);
    send_word(SAMPLE_BITS'(100), 12'd7, 1'b0);
    send_word(SAMPLE_BITS'(300), 12'd8, 1'b0);
    send_word(-SAMPLE_BITS'(50), 12'd8, 1'b0);
    send_word(SAMPLE_BITS'(500), 12'd8, 1'b0);
    send_word(-SAMPLE_BITS'(50), 12'd8, 1'b0);
    send_word(SAMPLE_BITS'(1), 12'd9, 1'b1);
    settle();
  endtask

  // Negative sums must truncate toward zero, and sums near full scale at
  // both ends must not wrap.
  task automatic test_average_truncation();
    set_mode(MODE_AVG);
    send_word(-SAMPLE_BITS'(7), 12'd100, 1'b0);
    send_word(-SAMPLE_BITS'(2), 12'd100, 1'b0);
    send_word(S_MAX, 12'd101, 1'b0);
    send_word(S_MAX, 12'd101, 1'b0);
    send_word(S_MAX - 1, 12'd101, 1'b1);
    send_word(S_MIN, 12'd102, 1'b0);
    send_word(-SAMPLE_BITS'(1), 12'd102, 1'b1);
    settle();
  endtask

  // After a frame end the next word opens a fresh bin even though its
  // index equals the one just closed.
  task automatic test_first_and_reopen();
    set_mode(MODE_FIRST);
    send_word(S_MIN, 12'd4095, 1'b1);
    send_word(SAMPLE_BITS'(42), 12'd4095, 1'b0);
    send_word(SAMPLE_BITS'(43), 12'd4095, 1'b1);
    settle();
  endtask

  // Random frames in several mode phases. Runs of one to six words share an
  // index; the index jumps anywhere, steps by one, stays, or falls in a small
  // set so that bins reopen after frame ends. A phase may end with a bin
  // still open, which then closes under the next mode.
  task automatic test_random_phases();
    logic [1:0]                    order [6] = '{MODE_MAX, MODE_AVG, MODE_FIRST,
                                                 MODE_MINMAX, MODE_AVG, MODE_MAX};
    logic [BIN_BITS-1:0]           b = '0;
    logic signed [SAMPLE_BITS-1:0] smp;
    int                            sent;
    int                            run_len;
    foreach (order[p]) begin
      set_mode(order[p]);
      sent = 0;
      while (sent < RANDOM_PHASE_WORDS) begin
        case ($urandom_range(0, 3))
          0: b = BIN_BITS'($urandom_range(0, 4095));
          1: b = b + 12'd1;
          2: b = BIN_BITS'($urandom_range(0, 3));
          default: ;
        endcase
        run_len = $urandom_range(1, 6);
        for (int k = 0; k < run_len; k++) begin
          case ($urandom_range(0, 7))
            0: smp = S_MAX;
            1: smp = S_MIN;
            // Small values make ties between samples common.
            2: smp = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
            default: smp = SAMPLE_BITS'($urandom);
          endcase
          send_word(smp, b, $urandom_range(0, 9) == 0);
          sent++;
        end
      end
      settle();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= MODE_MAX;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_mode_max();
    test_min_max_order();
    test_average_truncation();
    test_first_and_reopen();
    test_random_phases();

    $display("Covered all four modes, full-scale extremes, four-word steps and reopened");
    $display("bins: %0d sample words in, %0d result words checked, %0d errors.",
             words_sent, results_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdm_pkg.sv
rtl/bdm_fifo.sv
rtl/bdm_div.sv
rtl/bdm_front.sv
rtl/bdm_back.sv
rtl/bin_decimator_multimode_core.sv
dv/bin_decimator_multimode_core_test.sv
